[sv/assert_macros.svh]
// assertion macros shared by the frame parser modules
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VCFP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define VCFP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vcfp_pkg.sv]
// shared types, constants and helpers for the voice command frame parser
// no dependencies
package vcfp_pkg;

	// framing and command characters
	localparam logic [7:0] CH_OPEN  = 8'h24;
	localparam logic [7:0] CH_CLOSE = 8'h23;
	localparam logic [7:0] CH_CMD   = 8'h42;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// default payload capacity and value width
	localparam int PAYLOAD_BYTES_DEF = 20;
	localparam int VALUE_W           = 16;

	// number parse phases
	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	// result of one closing byte, from the parse core to the output stage
	typedef struct packed {
		logic               hit;
		logic               ok;
		logic [VALUE_W-1:0] value;
	} result_t;

	// white space as atoi sees it
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// decimal digit test
	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

[sv/vcfp_core.sv]
// frame state and byte-by-byte number parse, one byte per enabled cycle
// depends on vcfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module vcfp_core #(
	parameter int PAYLOAD_BYTES = vcfp_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	output vcfp_pkg::result_t res
);

	localparam int CntW = $clog2(PAYLOAD_BYTES + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(PAYLOAD_BYTES);

	logic                         in_frame_q, in_frame_d;
	logic [CntW-1:0]              count_q, count_d;
	logic                         first_b_q, first_b_d;
	vcfp_pkg::phase_t             phase_q, phase_d;
	logic                         neg_q, neg_d;
	logic [vcfp_pkg::VALUE_W-1:0] acc_q, acc_d;
	logic [vcfp_pkg::VALUE_W-1:0] latest_q, latest_d;
	logic [vcfp_pkg::VALUE_W-1:0] acc_mac;
	logic [vcfp_pkg::VALUE_W-1:0] signed_acc;
	logic                         digit;

	// acc * 10 + digit, wrapping to the value width
	assign digit   = vcfp_pkg::is_digit(rx_byte);
	assign acc_mac = (acc_q << 3) + (acc_q << 1)
		+ vcfp_pkg::VALUE_W'(rx_byte - vcfp_pkg::CH_ZERO);
	assign signed_acc = neg_q ? (~acc_q + 1'b1) : acc_q;

	// next state and result for the current byte
	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		first_b_d  = first_b_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		latest_d   = latest_q;
		res.hit    = 1'b0;
		res.ok     = first_b_q;
		res.value  = first_b_q ? signed_acc : latest_q;
		priority if (rx_byte == vcfp_pkg::CH_OPEN) begin
			in_frame_d = 1'b1;
			count_d    = '0;
			first_b_d  = 1'b0;
			phase_d    = vcfp_pkg::PH_SKIP;
			neg_d      = 1'b0;
			acc_d      = '0;
		end else if (rx_byte == vcfp_pkg::CH_CLOSE) begin
			res.hit = in_frame_q;
			if (in_frame_q && first_b_q) begin
				latest_d = signed_acc;
			end
			in_frame_d = 1'b0;
			count_d    = '0;
			first_b_d  = 1'b0;
			phase_d    = vcfp_pkg::PH_SKIP;
			neg_d      = 1'b0;
			acc_d      = '0;
		end else if (in_frame_q && count_q < CntMax) begin
			count_d = count_q + 1'b1;
			if (count_q == '0) begin
				first_b_d = (rx_byte == vcfp_pkg::CH_CMD);
			end else if (first_b_q) begin
				unique case (phase_q)
					vcfp_pkg::PH_SKIP: begin
						if (vcfp_pkg::is_space(rx_byte)) begin
							phase_d = vcfp_pkg::PH_SKIP;
						end else if (rx_byte == vcfp_pkg::CH_PLUS
							|| rx_byte == vcfp_pkg::CH_MINUS) begin
							neg_d   = (rx_byte == vcfp_pkg::CH_MINUS);
							phase_d = vcfp_pkg::PH_DIGITS;
						end else if (digit) begin
							acc_d   = acc_mac;
							phase_d = vcfp_pkg::PH_DIGITS;
						end else begin
							phase_d = vcfp_pkg::PH_DONE;
						end
					end
					vcfp_pkg::PH_DIGITS: begin
						if (digit) begin
							acc_d = acc_mac;
						end else begin
							phase_d = vcfp_pkg::PH_DONE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end else begin
			// byte outside a frame or past capacity is dropped
			count_d = count_q;
		end
	end

	// frame and parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			first_b_q  <= 1'b0;
			phase_q    <= vcfp_pkg::PH_SKIP;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			latest_q   <= '0;
		end else if (en) begin
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			first_b_q  <= first_b_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
			latest_q   <= latest_d;
		end
	end

	// a closing byte always leaves the frame closed
	`VCFP_ASSERT_NEXT(a_close_ends_frame, clk, arst_n,
		en && rx_byte == vcfp_pkg::CH_CLOSE, !in_frame_q, "frame still open after close")
	// the stored value moves only on a closed command frame
	`VCFP_ASSERT_NEXT(a_latest_only_on_cmd, clk, arst_n,
		!(en && res.hit && res.ok), $stable(latest_q), "stored value changed without command")

endmodule

[sv/voice_command_frame_parser.sv]
// top level of the voice command frame parser: input register, parse core, result register
// depends on vcfp_pkg, vcfp_core and assert_macros.svh
`include "assert_macros.svh"

// Takes one received byte per request and recognizes frames '$' payload '#'. Each '#'
// that closes an open frame gives one result request: command_ok is 1 when the first
// payload byte was 'B' (the rest then read as a signed decimal number, wrapped to 16 bits
// and stored), and command_value is the stored value after the frame. A byte is accepted
// every cycle as long as the result register can drain; cmd_valid rises once its closing
// byte has passed from the input register through the parse core into the result register.
// When a result waits under cmd_stall, a byte in the input register that does not produce a
// result still goes through, so only a closing byte that ends another frame is held back.
module voice_command_frame_parser #(
	parameter int PAYLOAD_BYTES = vcfp_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	output logic                         rx_stall,
	input  logic [7:0]                   rx_byte,
	output logic                         cmd_valid,
	input  logic                         cmd_stall,
	output logic                         command_ok,
	output logic [vcfp_pkg::VALUE_W-1:0] command_value
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         out_valid_q;
	logic                         out_ok_q;
	logic [vcfp_pkg::VALUE_W-1:0] out_value_q;
	logic                         out_free;
	logic                         advance;
	logic                         core_en;
	vcfp_pkg::result_t            core_res;

	// the byte in stage one moves on unless it makes a result with no room for it
	assign out_free = !out_valid_q || !cmd_stall;
	assign advance  = !core_res.hit || out_free;
	assign core_en  = valid_s1 && advance;
	assign rx_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	vcfp_core #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (core_en),
		.rx_byte(byte_s1),
		.res    (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_en && core_res.hit) begin
			out_valid_q <= 1'b1;
		end else if (!cmd_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en && core_res.hit) begin
			out_ok_q    <= core_res.ok;
			out_value_q <= core_res.value;
		end
	end

	assign cmd_valid     = out_valid_q;
	assign command_ok    = out_ok_q;
	assign command_value = out_value_q;

	// a new result never overwrites one still waiting
	`VCFP_ASSERT_SAME(a_load_has_room, clk, arst_n,
		core_en && core_res.hit, !out_valid_q || !cmd_stall, "result overwritten")
	// input is held back only behind a pending byte while a result waits under cmd_stall
	`VCFP_ASSERT_SAME(a_stall_needs_byte, clk, arst_n,
		rx_stall, valid_s1 && out_valid_q && cmd_stall, "input stalled with no cause")

endmodule
